FILE: design/tdvd_pkg.sv
// Shared types, constants and control bundles for the tremor detect vibration drive block.
package tdvd_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 5;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned THR_W     = 9;
  localparam int unsigned INT_W     = 8;
  localparam int unsigned DEV_W     = 10;
  localparam int unsigned PROD_W    = 18;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SAMPLE_W-1:0] CENTER = 10'd512;
  localparam logic [INT_W-1:0]    INT_MAX = 8'd255;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd300;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 9'd500;
  localparam logic [INT_W-1:0] LOW_RST = 8'd100;
  localparam logic [INT_W-1:0] HIGH_RST = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_LOW       = 2'd2,
    CFG_HIGH      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 button_low;
    logic                 sample_valid;
    logic [SAMPLE_W-1:0]  x_sample;
    logic [SAMPLE_W-1:0]  y_sample;
  } in_t;

  typedef struct packed {
    logic                system_on;
    logic                tremor_detected;
    logic [INT_W-1:0]    intensity;
    logic [SAMPLE_W-1:0] smooth_x;
    logic [SAMPLE_W-1:0] smooth_y;
  } out_t;

  typedef struct packed {
    logic load;
    logic avg_mul;
    logic avg_fix;
    logic compare;
    logic div_step;
    logic map;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic take_sample;
    logic over;
  } ctrl_sts_t;

endpackage

FILE: design/tdvd_ctrl.sv
// Sequencer for the tremor detector: steps one transaction through the datapath.
module tdvd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tdvd_pkg::ctrl_sts_t sts_i,
  output tdvd_pkg::ctrl_cmd_t cmd_o
);
  import tdvd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_CMP,
    ST_DIV,
    ST_MAP,
    ST_DONE
  } state_e;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_free    = !out_valid_q || !out_stall_i;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts_i.take_sample) begin
          cmd_o.avg_mul = 1'b1;
          state_d       = ST_FIX;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FIX: begin
        cmd_o.avg_fix = 1'b1;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        if (sts_i.over) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_MAP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/tdvd_datapath.sv
// Datapath: config registers, debounce counter, moving averages, threshold and mapping divider.
module tdvd_datapath #(
  parameter int unsigned WINDOW_LEN = tdvd_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tdvd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tdvd_pkg::CFG_W-1:0]         cfg_data_i,
  input  tdvd_pkg::in_t                      in_data_i,
  output tdvd_pkg::out_t                     out_data_o,
  input  tdvd_pkg::ctrl_cmd_t                cmd_i,
  output tdvd_pkg::ctrl_sts_t                sts_o
);
  import tdvd_pkg::*;

  localparam int unsigned NSTORE = WINDOW_LEN - 1;
  localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
  localparam int unsigned RCP_K  = SUM_W;
  localparam int unsigned MUL_W  = SUM_W + RCP_K;
  localparam logic [RCP_K-1:0] RCP_C = RCP_K'((1 << RCP_K) / WINDOW_LEN);
  localparam logic [SUM_W:0]   WIN_C = (SUM_W + 1)'(WINDOW_LEN);

  // configuration
  logic [CFG_W-1:0] debounce_q;
  logic [THR_W-1:0] thr_q;
  logic [INT_W-1:0] low_q;
  logic [INT_W-1:0] high_q;

  // architectural state
  logic                en_q;
  logic [CNT_W-1:0]    ms_q;
  logic [SAMPLE_W-1:0] win_x_q [NSTORE];
  logic [SAMPLE_W-1:0] win_y_q [NSTORE];
  logic [SUM_W-1:0]    wsum_x_q, wsum_y_q;
  logic [SAMPLE_W-1:0] sx_q, sy_q;
  logic                tremor_q;
  logic [INT_W-1:0]    int_q;

  // per transaction working registers
  in_t                 in_q;
  logic [SUM_W-1:0]    sum_x_q, sum_y_q;
  logic [MUL_W-1:0]    prod_x_q, prod_y_q;
  logic                neg_q;
  logic [PROD_W-1:0]   dvd_q;
  logic [DEV_W:0]      rem_q;
  logic [DEV_W-1:0]    den_q;
  out_t                out_q;

  // combinational
  logic [CNT_W:0]      ms_sum;
  logic [CNT_W-1:0]    ms_sat;
  logic                toggle;
  logic                en_d;
  logic [SUM_W-1:0]    sum_x_d, sum_y_d;
  logic [SAMPLE_W-1:0] avg_x, avg_y;
  logic [DEV_W-1:0]    dev_x, dev_y, dmax, num;
  logic                over;
  logic                neg_d;
  logic [INT_W-1:0]    mag;
  logic [DEV_W:0]      rem_sh;
  logic                ge;
  logic [PROD_W:0]     up_sum;
  logic [INT_W-1:0]    map_val;

  // reciprocal estimate is exact or one short; one compare fixes it
  function automatic logic [SAMPLE_W-1:0] fix_avg(input logic [SUM_W-1:0] s,
                                                  input logic [SAMPLE_W-1:0] q0);
    logic [SUM_W:0] nxt;
    nxt = ((SUM_W + 1)'(q0) + 1'b1) * WIN_C;
    return ({1'b0, s} >= nxt) ? q0 + 1'b1 : q0;
  endfunction

  function automatic logic [DEV_W-1:0] dev_of(input logic [SAMPLE_W-1:0] avg);
    return (avg >= CENTER) ? DEV_W'(avg - CENTER) : DEV_W'(CENTER - avg);
  endfunction

  always_comb begin
    ms_sum = (CNT_W + 1)'(ms_q) + (CNT_W + 1)'(in_data_i.elapsed_ms);
    ms_sat = ms_sum[CNT_W] ? '1 : ms_sum[CNT_W-1:0];
    toggle = in_data_i.button_low && (ms_sat > CNT_W'(debounce_q));
    en_d   = en_q ^ toggle;

    sum_x_d = wsum_x_q + SUM_W'(in_q.x_sample);
    sum_y_d = wsum_y_q + SUM_W'(in_q.y_sample);
    avg_x   = fix_avg(sum_x_q, prod_x_q[RCP_K +: SAMPLE_W]);
    avg_y   = fix_avg(sum_y_q, prod_y_q[RCP_K +: SAMPLE_W]);

    dev_x = dev_of(sx_q);
    dev_y = dev_of(sy_q);
    dmax  = (dev_x > dev_y) ? dev_x : dev_y;
    over  = dmax > DEV_W'(thr_q);
    num   = dmax - DEV_W'(thr_q);
    neg_d = high_q < low_q;
    mag   = neg_d ? (low_q - high_q) : (high_q - low_q);

    rem_sh = {rem_q[DEV_W-1:0], dvd_q[PROD_W-1]};
    ge     = rem_sh >= {1'b0, den_q};

    up_sum = (PROD_W + 1)'(dvd_q) + (PROD_W + 1)'(low_q);
    if (!neg_q) begin
      map_val = (up_sum > (PROD_W + 1)'(INT_MAX)) ? INT_MAX : up_sum[INT_W-1:0];
    end else begin
      map_val = (dvd_q > PROD_W'(low_q)) ? '0 : (low_q - dvd_q[INT_W-1:0]);
    end
  end

  assign sts_o.take_sample = en_q && in_q.sample_valid;
  assign sts_o.over        = over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      thr_q      <= THRESHOLD_RST;
      low_q      <= LOW_RST;
      high_q     <= HIGH_RST;
      en_q       <= 1'b0;
      ms_q       <= '0;
      wsum_x_q   <= '0;
      wsum_y_q   <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      tremor_q   <= 1'b0;
      int_q      <= '0;
      for (int i = 0; i < NSTORE; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE:  debounce_q <= cfg_data_i;
          CFG_THRESHOLD: thr_q      <= cfg_data_i[THR_W-1:0];
          CFG_LOW:       low_q      <= cfg_data_i[INT_W-1:0];
          CFG_HIGH:      high_q     <= cfg_data_i[INT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        en_q <= en_d;
        ms_q <= toggle ? '0 : ms_sat;
        if (!en_d) begin
          tremor_q <= 1'b0;
          int_q    <= '0;
        end
      end
      if (cmd_i.avg_fix) begin
        sx_q     <= avg_x;
        sy_q     <= avg_y;
        wsum_x_q <= sum_x_q - SUM_W'(win_x_q[0]);
        wsum_y_q <= sum_y_q - SUM_W'(win_y_q[0]);
        for (int i = 0; i < NSTORE - 1; i++) begin
          win_x_q[i] <= win_x_q[i+1];
          win_y_q[i] <= win_y_q[i+1];
        end
        win_x_q[NSTORE-1] <= in_q.x_sample;
        win_y_q[NSTORE-1] <= in_q.y_sample;
      end
      if (cmd_i.compare) begin
        tremor_q <= over;
        if (!over) begin
          int_q <= '0;
        end
      end
      if (cmd_i.map) begin
        int_q <= map_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.avg_mul) begin
      sum_x_q  <= sum_x_d;
      sum_y_q  <= sum_y_d;
      prod_x_q <= MUL_W'(sum_x_d) * MUL_W'(RCP_C);
      prod_y_q <= MUL_W'(sum_y_d) * MUL_W'(RCP_C);
    end
    if (cmd_i.compare) begin
      neg_q <= neg_d;
      dvd_q <= PROD_W'(num) * PROD_W'(mag);
      den_q <= DEV_W'(CENTER) - DEV_W'(thr_q);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      dvd_q <= {dvd_q[PROD_W-2:0], ge};
    end
    if (cmd_i.emit) begin
      out_q.system_on       <= en_q;
      out_q.tremor_detected <= tremor_q;
      out_q.intensity       <= int_q;
      out_q.smooth_x        <= sx_q;
      out_q.smooth_y        <= sy_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: design/tremor_detect_vibration_drive_unit.sv
// Top level of the tremor detector and vibration drive.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// time step, carrying elapsed milliseconds, the button level and an optional
// X/Y sample pair. Output channel (out_valid_o / out_stall_i / out_data_o):
// exactly one result per input transaction, in order.
// Items are handled one at a time by a sequencer driving a shared datapath.
// Without a sample (or while off) an item passes from the load through the MUL
// and DONE states; a sample under the threshold also passes FIX and CMP; when
// tremor is found, the 18 steps of the bit-serial divider that maps deviation
// to drive level and the MAP state follow CMP. A new item is taken only once
// the sequencer is back in idle after the result is loaded.
// The result sits in an output register: a stalled receiver holds it steady
// while the next item is already being processed; that item then waits for
// the register to free up. Reset clears the on flag, the debounce counter,
// both sample windows, the held averages and drive level, and loads the
// configuration registers with their defaults.
module tremor_detect_vibration_drive_unit #(
  parameter int unsigned WINDOW_LEN = tdvd_pkg::WINDOW_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tdvd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tdvd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tdvd_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tdvd_pkg::out_t                 out_data_o
);
  import tdvd_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tdvd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tdvd_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

FILE: design/tdvd_checker.sv
// Port-level checks for the tremor detector, bound to the top level.
module tdvd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tdvd_pkg::out_t out_data_o
);

  // a result waiting on the receiver must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // one transaction in flight: the input closes right after acceptance
  a_in_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous transaction still in work");

  // switched off means no drive
  a_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.system_on |->
      !out_data_o.tremor_detected && (out_data_o.intensity == '0))
    else $error("drive reported while system off");

  a_no_tremor_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tremor_detected |-> (out_data_o.intensity == '0))
    else $error("nonzero intensity without tremor");

endmodule

bind tremor_detect_vibration_drive_unit tdvd_checker u_tdvd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
